>>> hw/rtl/user_range_access_check_assert.svh
// ----------------------------------------------------------------------------
// User range access check - assertion macros
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef USER_RANGE_ACCESS_CHECK_ASSERT_SVH
`define USER_RANGE_ACCESS_CHECK_ASSERT_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent
`define URAC_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in %m");

// Consequent must hold in the cycle after the antecedent
`define URAC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in %m");

`else

`define URAC_ASSERT_SAME(name, ante, cons)
`define URAC_ASSERT_NEXT(name, ante, cons)

`endif

`endif

>>> hw/rtl/urac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// User range access check - shared package
// Field widths, codes and the command/status structs between control and
// datapath.
// ----------------------------------------------------------------------------
package urac_pkg;

    localparam int USER_SLOTS_DEF = 768;

    localparam int ADDR_W         = 32;
    localparam int LEN_W          = 32;
    localparam int PAGE_SH        = 12;              // byte address to page number
    localparam int PAGE_W         = ADDR_W - PAGE_SH;
    localparam int SLOT_SH        = 10;              // page number to directory slot
    localparam int SLOT_NUM_W     = PAGE_W - SLOT_SH;
    localparam int PAGES_PER_SLOT = 1 << SLOT_SH;

    // Page bits are stored sixteen pages to a memory row
    localparam int ENTRY_W        = 2;
    localparam int ROW_PAGES      = 16;
    localparam int ROW_SEL_W      = $clog2(ROW_PAGES);
    localparam int ROW_BITS       = ROW_PAGES * ENTRY_W;
    localparam int BIT_PRESENT    = 0;
    localparam int BIT_WRITABLE   = 1;

    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 32;
    localparam logic [ADDR_W-1:0] KERNEL_BASE_RST = 32'hC000_0000;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_KERNEL_BASE = 1'b0;
    localparam cfg_idx_t CFG_TASK_ACTIVE = 1'b1;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_PAGE  = 2'd0;
    localparam kind_t KIND_SLOT  = 2'd1;
    localparam kind_t KIND_CHECK = 2'd2;

    typedef logic [2:0] reason_t;
    localparam reason_t RSN_OK        = 3'd0;
    localparam reason_t RSN_WRAP      = 3'd1;
    localparam reason_t RSN_KERNEL    = 3'd2;
    localparam reason_t RSN_NO_TASK   = 3'd3;
    localparam reason_t RSN_NO_TABLE  = 3'd4;
    localparam reason_t RSN_NOT_PRES  = 3'd5;
    localparam reason_t RSN_READ_ONLY = 3'd6;

    typedef struct packed {
        logic capture;       // take the incoming item
        logic pre_load;      // register the last page of the range
        logic walk_adv;      // step to the next page
        logic finish_early;  // result from the range screen
        logic finish_walk;   // result from the page walk
        logic finish_ok;     // load item result
        logic load_write;    // apply a load item to the map
        logic clear;         // one step of the clearing pass
        logic rsp_load;      // move the result into the output register
    } cmd_t;

    typedef struct packed {
        logic req_is_check;
        logic early_hit;
        logic walk_done;
        logic clear_last;
    } status_t;

endpackage

>>> hw/rtl/urac_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// User range access check - channel interfaces
// Request channel (loads and checks) and response channel.
// ----------------------------------------------------------------------------
interface urac_req_if;
    import urac_pkg::*;

    logic                valid;
    logic                ready;
    kind_t               kind;
    logic [ADDR_W-1:0]   address;
    logic [LEN_W-1:0]    length;
    logic                write_access;
    logic                slot_present;
    logic                page_present;
    logic                page_writable;

    modport source (
        output valid, kind, address, length, write_access,
               slot_present, page_present, page_writable,
        input  ready
    );

    modport sink (
        input  valid, kind, address, length, write_access,
               slot_present, page_present, page_writable,
        output ready
    );
endinterface

interface urac_rsp_if;
    import urac_pkg::*;

    logic    valid;
    logic    ready;
    logic    allowed;
    reason_t fail_reason;

    modport source (
        output valid, allowed, fail_reason,
        input  ready
    );

    modport sink (
        input  valid, allowed, fail_reason,
        output ready
    );
endinterface

>>> hw/rtl/user_range_access_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// User range access check - top level
// Two-level user page map with a per-page permission walk over a byte range.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the page and slot memories,
// stepping through the USER_SLOTS * 64 page memory rows (49152 at the default
// of 768 slots) with ready low; configuration writes are taken throughout.
// Items are then handled one at a time. A check that the range screen
// settles (wrap, kernel space, empty range, no task) skips the page walk;
// other checks walk the map up to the first failing page or the last page,
// reading one page per cycle from the page memory. Results sit in an output
// register, so acceptance resumes once it has room.
// ----------------------------------------------------------------------------
module user_range_access_check #(
    parameter int USER_SLOTS = urac_pkg::USER_SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    urac_req_if.sink                        req,
    urac_rsp_if.source                      rsp,
    input  logic                            cfg_we,
    input  urac_pkg::cfg_idx_t              cfg_index,
    input  logic [urac_pkg::CFG_DATA_W-1:0] cfg_data
);
    import urac_pkg::*;

    `include "user_range_access_check_assert.svh"

    cmd_t    cmd;
    status_t sts;

    urac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    urac_dp #(
        .USER_SLOTS (USER_SLOTS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .req_kind          (req.kind),
        .req_address       (req.address),
        .req_length        (req.length),
        .req_write_access  (req.write_access),
        .req_slot_present  (req.slot_present),
        .req_page_present  (req.page_present),
        .req_page_writable (req.page_writable),
        .rsp_allowed       (rsp.allowed),
        .rsp_fail_reason   (rsp.fail_reason),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    `URAC_ASSERT_SAME(a_no_accept_in_clear, cmd.clear, !req.ready)
    `URAC_ASSERT_NEXT(a_one_item_at_a_time, req.valid && req.ready, !req.ready)
    `URAC_ASSERT_SAME(a_walk_stops_at_end, cmd.walk_adv, !sts.walk_done)

endmodule

>>> hw/rtl/urac_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// User range access check - controller
// Sequences clearing, range screen, page walk, loads and the response.
// ----------------------------------------------------------------------------
module urac_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    input  urac_pkg::status_t sts,
    output urac_pkg::cmd_t    cmd
);
    import urac_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_PRE   = 3'd2;
    localparam logic [2:0] ST_WALK  = 3'd3;
    localparam logic [2:0] ST_LOAD  = 3'd4;
    localparam logic [2:0] ST_RESP  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = sts.req_is_check ? ST_PRE : ST_LOAD;
                end
            end
            ST_PRE:
            begin
                cmd.pre_load = 1'b1;
                if (sts.early_hit)
                begin
                    cmd.finish_early = 1'b1;
                    state_next       = ST_RESP;
                end
                else
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (sts.walk_done)
                begin
                    cmd.finish_walk = 1'b1;
                    state_next      = ST_RESP;
                end
                else
                begin
                    cmd.walk_adv = 1'b1;
                end
            end
            ST_LOAD:
            begin
                cmd.load_write = 1'b1;
                cmd.finish_ok  = 1'b1;
                state_next     = ST_RESP;
            end
            ST_RESP:
            begin
                // hold until the output register is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.rsp_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

>>> hw/rtl/urac_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// User range access check - datapath
// Item registers, range screen, page walk, slot and page memories,
// configuration registers and the response register.
// ----------------------------------------------------------------------------
module urac_dp #(
    parameter int USER_SLOTS = urac_pkg::USER_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  urac_pkg::cmd_t                 cmd,
    output urac_pkg::status_t              sts,
    input  urac_pkg::kind_t                req_kind,
    input  logic [urac_pkg::ADDR_W-1:0]    req_address,
    input  logic [urac_pkg::LEN_W-1:0]     req_length,
    input  logic                           req_write_access,
    input  logic                           req_slot_present,
    input  logic                           req_page_present,
    input  logic                           req_page_writable,
    output logic                           rsp_allowed,
    output urac_pkg::reason_t              rsp_fail_reason,
    input  logic                           cfg_we,
    input  urac_pkg::cfg_idx_t             cfg_index,
    input  logic [urac_pkg::CFG_DATA_W-1:0] cfg_data
);
    import urac_pkg::*;

    localparam int ROWS   = USER_SLOTS * (PAGES_PER_SLOT / ROW_PAGES);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int SLOT_W = (USER_SLOTS > 1) ? $clog2(USER_SLOTS) : 1;
    localparam logic [SLOT_NUM_W:0] SLOT_LIM  = (SLOT_NUM_W + 1)'(USER_SLOTS);
    localparam logic [ROW_W-1:0]    CLR_LAST  = ROW_W'(ROWS - 1);
    localparam logic [ROW_W-1:0]    CLR_SLOTS = ROW_W'(USER_SLOTS);

    // configuration
    logic [ADDR_W-1:0] kernel_base_reg;
    logic              task_active_reg;

    // captured item
    kind_t             kind_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [LEN_W-1:0]  len_reg;
    logic              write_access_reg;
    logic              slot_present_reg;
    logic              page_present_reg;
    logic              page_writable_reg;

    logic [PAGE_W-1:0] pg_reg;
    logic [PAGE_W-1:0] pg_next;
    logic [PAGE_W-1:0] last_reg;
    logic [PAGE_W-1:0] last_next;
    logic [ROW_W-1:0]  clr_reg;
    logic [ROW_W-1:0]  clr_next;
    reason_t           reason_reg;
    reason_t           reason_next;
    reason_t           rsp_reason_reg;

    // memories
    logic [ROW_BITS-1:0] row_mem [ROWS];
    logic                slot_mem [USER_SLOTS];
    logic [ROW_BITS-1:0] row_q;
    logic                slot_q;

    logic                row_we;
    logic [ROW_W-1:0]    row_wa;
    logic [ROW_BITS-1:0] row_wd;
    logic [ROW_BITS-1:0] row_mod;
    logic                slot_we;
    logic [SLOT_W-1:0]   slot_wa;
    logic                slot_wd;

    // range screen
    logic [ADDR_W:0]     end_sum;
    logic [ADDR_W-1:0]   end_addr;
    logic [ADDR_W-1:0]   end_m1;
    logic                wrap_hit;
    logic                kern_hit;
    logic                empty_hit;
    reason_t             early_reason;

    // page walk
    logic                slot_bad;
    logic [ENTRY_W-1:0]  entry;
    reason_t             walk_reason;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_base_reg <= KERNEL_BASE_RST;
            task_active_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KERNEL_BASE: kernel_base_reg <= cfg_data[ADDR_W-1:0];
                CFG_TASK_ACTIVE: task_active_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg          <= req_kind;
            addr_reg          <= req_address;
            len_reg           <= req_length;
            write_access_reg  <= req_write_access;
            slot_present_reg  <= req_slot_present;
            page_present_reg  <= req_page_present;
            page_writable_reg <= req_page_writable;
        end
        pg_reg     <= pg_next;
        last_reg   <= last_next;
        reason_reg <= reason_next;
        if (cmd.rsp_load)
        begin
            rsp_reason_reg <= reason_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else
        begin
            clr_reg <= clr_next;
        end
    end

    assign clr_next = cmd.clear ? (clr_reg + ROW_W'(1)) : clr_reg;

    // page pointer: the memories are read at its next value
    always_comb
    begin
        priority if (cmd.capture)
        begin
            pg_next = req_address[ADDR_W-1:PAGE_SH];
        end
        else if (cmd.walk_adv)
        begin
            pg_next = pg_reg + PAGE_W'(1);
        end
        else
        begin
            pg_next = pg_reg;
        end
    end

    assign end_sum   = {1'b0, addr_reg} + {1'b0, len_reg};
    assign end_addr  = end_sum[ADDR_W-1:0];
    assign end_m1    = end_addr - ADDR_W'(1);
    assign wrap_hit  = end_sum[ADDR_W];
    assign kern_hit  = (addr_reg >= kernel_base_reg) || (end_addr > kernel_base_reg);
    assign empty_hit = (len_reg == '0);
    assign last_next = cmd.pre_load ? end_m1[ADDR_W-1:PAGE_SH] : last_reg;

    always_comb
    begin
        priority if (wrap_hit)
        begin
            early_reason = RSN_WRAP;
        end
        else if (kern_hit)
        begin
            early_reason = RSN_KERNEL;
        end
        else if (empty_hit)
        begin
            early_reason = RSN_OK;
        end
        else
        begin
            early_reason = RSN_NO_TASK;
        end
    end

    assign slot_bad = {1'b0, pg_reg[PAGE_W-1:SLOT_SH]} >= SLOT_LIM;
    assign entry    = row_q[{pg_reg[ROW_SEL_W-1:0], 1'b0} +: ENTRY_W];

    always_comb
    begin
        priority if (slot_bad)
        begin
            walk_reason = RSN_KERNEL;
        end
        else if (!slot_q)
        begin
            walk_reason = RSN_NO_TABLE;
        end
        else if (!entry[BIT_PRESENT])
        begin
            walk_reason = RSN_NOT_PRES;
        end
        else if (write_access_reg && !entry[BIT_WRITABLE])
        begin
            walk_reason = RSN_READ_ONLY;
        end
        else
        begin
            walk_reason = RSN_OK;
        end
    end

    always_comb
    begin
        priority if (cmd.finish_early)
        begin
            reason_next = early_reason;
        end
        else if (cmd.finish_walk)
        begin
            reason_next = walk_reason;
        end
        else if (cmd.finish_ok)
        begin
            reason_next = RSN_OK;
        end
        else
        begin
            reason_next = reason_reg;
        end
    end

    // replace one page's bits in the row read for this load
    always_comb
    begin
        row_mod = row_q;
        for (int k = 0; k < ROW_PAGES; k++)
        begin
            if (pg_reg[ROW_SEL_W-1:0] == ROW_SEL_W'(k))
            begin
                row_mod[k*ENTRY_W + BIT_PRESENT]  = page_present_reg;
                row_mod[k*ENTRY_W + BIT_WRITABLE] = page_writable_reg;
            end
        end
    end

    assign row_we  = cmd.clear ||
                     (cmd.load_write && (kind_reg == KIND_PAGE) && !slot_bad);
    assign row_wa  = cmd.clear ? clr_reg : pg_reg[ROW_SEL_W +: ROW_W];
    assign row_wd  = cmd.clear ? '0 : row_mod;
    assign slot_we = (cmd.clear && (clr_reg < CLR_SLOTS)) ||
                     (cmd.load_write && (kind_reg == KIND_SLOT) && !slot_bad);
    assign slot_wa = cmd.clear ? clr_reg[SLOT_W-1:0] : pg_reg[SLOT_SH +: SLOT_W];
    assign slot_wd = cmd.clear ? 1'b0 : slot_present_reg;

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[row_wa] <= row_wd;
        end
        row_q <= row_mem[pg_next[ROW_SEL_W +: ROW_W]];
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_wa] <= slot_wd;
        end
        slot_q <= slot_mem[pg_next[SLOT_SH +: SLOT_W]];
    end

    assign sts.req_is_check = (req_kind == KIND_CHECK);
    assign sts.early_hit    = wrap_hit || kern_hit || empty_hit || !task_active_reg;
    assign sts.walk_done    = (walk_reason != RSN_OK) || (pg_reg == last_reg);
    assign sts.clear_last   = (clr_reg == CLR_LAST);

    assign rsp_allowed     = (rsp_reason_reg == RSN_OK);
    assign rsp_fail_reason = rsp_reason_reg;

endmodule
